[rtl/pscm_pkg.sv]
// Shared constants, command/status types and controller states for the crossing marker.
package pscm_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 12;
	localparam int IDX_W        = 6;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_SUM
	} state_t;

	typedef struct packed {
		logic             store;
		logic             start;
		logic             issue;
		logic [IDX_W-1:0] rd_addr;
		logic             load_sum;
		logic             sum_full;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             busy;
		logic             adv;
	} sts_t;

endpackage

[rtl/pscm_ctrl.sv]
// Controller: input acceptance, segment sweep sequencing and summary issue.
module pscm_ctrl import pscm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	input  logic   click,
	output logic   s_tready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] j_q;
	logic             full_q;
	logic             acc;
	logic             full;
	logic             short_line;
	logic [IDX_W-1:0] j_last;

	assign full       = sts.count >= CNT_W'(MAX_VERTICES);
	assign short_line = sts.count < CNT_W'(3);
	assign acc        = s_tvalid && (state_q == ST_IDLE) && click;
	// after the store, count = k+1; last vertex read is k-2
	assign j_last     = IDX_W'(sts.count - CNT_W'(3));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (full || short_line)
						state_d = ST_SUM;
					else
						state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sts.adv && (j_q == j_last))
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.busy)
					state_d = ST_SUM;
			end
			ST_SUM: begin
				if (sts.adv)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		cmd.store    = acc && !full;
		cmd.start    = acc && !full;
		cmd.issue    = (state_q == ST_SWEEP);
		cmd.rd_addr  = j_q;
		cmd.load_sum = (state_q == ST_SUM) && sts.adv;
		cmd.sum_full = full_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE)
				j_q <= '0;
			else if (state_q == ST_SWEEP && sts.adv)
				j_q <= j_q + IDX_W'(1);
			if (acc)
				full_q <= full;
		end
	end

`ifndef SYNTHESIS
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !sts.busy)
		else $error("pipeline busy while idle");
	a_sweep_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (sts.count >= CNT_W'(4)))
		else $error("sweep with too few vertices");
`endif

endmodule

[rtl/pscm_dp.sv]
// Datapath: vertex store, orientation pipeline, marks, hit count and output register.
module pscm_dp import pscm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	output logic                  m_tuser
);

	logic [2*COORD_BITS-1:0] vmem [MAX_VERTICES];

	logic [CNT_W-1:0]        vcount_q;
	logic [IDX_W-1:0]        vidx_q;
	logic [IDX_W-1:0]        hits_q;
	logic [MAX_VERTICES-1:0] marks_q;
	logic [COORD_BITS-1:0]   q0x_q, q0y_q, q1x_q, q1y_q;
	logic [COORD_BITS-1:0]   px, py;
	logic                    adv;

	// stage 1: vertex read
	logic                    v_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [2*COORD_BITS-1:0] rd_s1;
	logic [COORD_BITS-1:0]   prvx_q, prvy_q;
	logic [COORD_BITS-1:0]   bx, by;

	// stage 2: differences
	logic                    v_s2;
	logic [IDX_W-1:0]        seg_s2;
	logic signed [DIFF_W-1:0] ux_s2, uy_s2, v1x_s2, v1y_s2, v2x_s2, v2y_s2;
	logic signed [DIFF_W-1:0] wx_s2, wy_s2, e1x_s2, e1y_s2, e2x_s2, e2y_s2;

	// stage 3: products
	logic                    v_s3;
	logic [IDX_W-1:0]        seg_s3;
	logic signed [PROD_W-1:0] p1a_s3, p1b_s3, p2a_s3, p2b_s3;
	logic signed [PROD_W-1:0] p3a_s3, p3b_s3, p4a_s3, p4b_s3;
	logic signed [CROSS_W-1:0] d1, d2, d3, d4;
	logic                    hit;

	// stage 4: decision
	logic                    hit_s4;
	logic [IDX_W-1:0]        seg_s4;

	// output register
	logic                    out_v_q;
	logic                    out_crossed_q;
	logic [IDX_W-1:0]        out_hit_q;
	logic                    out_acc_q;
	logic                    out_full_q;
	logic [IDX_W-1:0]        out_vidx_q;
	logic [IDX_W-1:0]        out_cnt_q;
	logic                    out_last_q;

	function automatic logic signed [DIFF_W-1:0] sdiff(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b);
		sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	assign px  = s_tdata[COORD_BITS-1:0];
	assign py  = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign adv = !out_v_q || m_tready;

	assign sts.count = vcount_q;
	assign sts.busy  = v_s1 || v_s2 || v_s3 || hit_s4;
	assign sts.adv   = adv;

	always_ff @(posedge clk) begin
		if (cmd.store)
			vmem[vcount_q[IDX_W-1:0]] <= {py, px};
		if (cmd.issue && adv)
			rd_s1 <= vmem[cmd.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			vidx_q   <= '0;
			hits_q   <= '0;
			marks_q  <= '0;
		end else begin
			if (cmd.store) begin
				vcount_q <= vcount_q + CNT_W'(1);
				vidx_q   <= vcount_q[IDX_W-1:0];
			end
			if (cmd.start)
				hits_q <= '0;
			else if (adv && hit_s4)
				hits_q <= hits_q + IDX_W'(1);
			// mark the earlier segment and the new one
			if (adv && hit_s4)
				marks_q <= marks_q | (MAX_VERTICES'(1) << seg_s4)
					| (MAX_VERTICES'(1) << (vidx_q - IDX_W'(1)));
		end
	end

	// newest vertex and the one before it
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			q0x_q <= q1x_q;
			q0y_q <= q1y_q;
			q1x_q <= px;
			q1y_q <= py;
		end
	end

	assign bx = rd_s1[COORD_BITS-1:0];
	assign by = rd_s1[2*COORD_BITS-1:COORD_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			hit_s4 <= 1'b0;
		end else if (adv) begin
			v_s1   <= cmd.issue;
			v_s2   <= v_s1 && (idx_s1 != '0);
			v_s3   <= v_s2;
			hit_s4 <= v_s3 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= cmd.rd_addr;
			if (v_s1) begin
				prvx_q <= bx;
				prvy_q <= by;
			end
			// segment (prev, cur), index prev
			seg_s2 <= idx_s1 - IDX_W'(1);
			ux_s2  <= sdiff(bx, prvx_q);
			uy_s2  <= sdiff(by, prvy_q);
			v1x_s2 <= sdiff(q0x_q, prvx_q);
			v1y_s2 <= sdiff(q0y_q, prvy_q);
			v2x_s2 <= sdiff(q1x_q, prvx_q);
			v2y_s2 <= sdiff(q1y_q, prvy_q);
			wx_s2  <= sdiff(q1x_q, q0x_q);
			wy_s2  <= sdiff(q1y_q, q0y_q);
			e1x_s2 <= sdiff(prvx_q, q0x_q);
			e1y_s2 <= sdiff(prvy_q, q0y_q);
			e2x_s2 <= sdiff(bx, q0x_q);
			e2y_s2 <= sdiff(by, q0y_q);

			seg_s3 <= seg_s2;
			p1a_s3 <= ux_s2 * v1y_s2;
			p1b_s3 <= uy_s2 * v1x_s2;
			p2a_s3 <= ux_s2 * v2y_s2;
			p2b_s3 <= uy_s2 * v2x_s2;
			p3a_s3 <= wx_s2 * e1y_s2;
			p3b_s3 <= wy_s2 * e1x_s2;
			p4a_s3 <= wx_s2 * e2y_s2;
			p4b_s3 <= wy_s2 * e2x_s2;

			seg_s4 <= seg_s3;
		end
	end

	assign d1 = CROSS_W'(p1a_s3) - CROSS_W'(p1b_s3);
	assign d2 = CROSS_W'(p2a_s3) - CROSS_W'(p2b_s3);
	assign d3 = CROSS_W'(p3a_s3) - CROSS_W'(p3b_s3);
	assign d4 = CROSS_W'(p4a_s3) - CROSS_W'(p4b_s3);

	// strict side change of the new endpoints; segment ends not both on one side
	assign hit = ((d1 > 0 && d2 < 0) || (d1 < 0 && d2 > 0))
		&& !((d3 > 0 && d4 > 0) || (d3 < 0 && d4 < 0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (adv)
			out_v_q <= hit_s4 || cmd.load_sum;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (hit_s4) begin
				out_crossed_q <= 1'b1;
				out_hit_q     <= seg_s4;
				out_acc_q     <= 1'b1;
				out_full_q    <= 1'b0;
				out_vidx_q    <= vidx_q;
				out_cnt_q     <= '0;
				out_last_q    <= 1'b0;
			end else begin
				out_crossed_q <= 1'b0;
				out_hit_q     <= '0;
				out_acc_q     <= !cmd.sum_full;
				out_full_q    <= cmd.sum_full;
				out_vidx_q    <= cmd.sum_full ? '0 : vidx_q;
				out_cnt_q     <= cmd.sum_full ? '0 : hits_q;
				out_last_q    <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_crossed_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0, out_cnt_q, out_vidx_q, out_full_q, out_acc_q, out_hit_q};

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond store depth");
	a_cross_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_crossed_q) |-> (!out_last_q && out_acc_q))
		else $error("crossing result flagged as summary");
	a_hit_vs_sum: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s4 |-> !cmd.load_sum)
		else $error("summary issued while crossing pending");
	a_hits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(hits_q != '0) |-> (vidx_q >= IDX_W'(3)))
		else $error("crossing counted on short polyline");
`endif

endmodule

[rtl/polyline_self_crossing_marker.sv]
// Polyline self-crossing marker: top level joining controller and datapath.
// Input stream: one transfer per event. s_tuser is the click flag; events with it low are
//   consumed and produce nothing. s_tdata carries the vertex coordinates.
// Output stream: each stored vertex k yields one transfer per earlier segment it crosses
//   (m_tuser high, segment index in hit_segment), then a summary transfer with m_tlast high
//   carrying the crossing count. A click with the 64-entry store full yields only a
//   summary with store_full set.
// Timing: s_tready is high only while idle. A vertex with k >= 3 sweeps segments
//   0..k-3 reading one stored vertex per cycle from the single-port vertex memory while
//   m_tready does not stall the output, then lets the read, difference, product and
//   decision stages drain and issues the summary. k < 3 or a full store goes straight to it.
// A stalled m_tready freezes the whole orientation pipeline; nothing is dropped. The
//   output register lets the next click be taken while the last summary waits.
// Reset (arst_n low) empties the store, clears segment marks and returns to idle;
//   no clearing pass is needed.
module polyline_self_crossing_marker import pscm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // px, py
	input  logic                  s_tuser,   // click_valid
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // hit_segment, accepted, store_full,
	                                         // vertex_index, crossing_count, zero pad
	output logic                  m_tlast,   // last
	output logic                  m_tuser    // crossed
);

	cmd_t cmd;
	sts_t sts;

	pscm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.click    (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pscm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

[tb/sv/crossing_report_checker.sv]
// Crossing marker checker: watches both streams, predicts the reports of each click and compares.
module crossing_report_checker import pscm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // px, py
	input  logic                  s_tuser,   // click_valid
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // hit_segment, accepted, store_full,
	                                         // vertex_index, crossing_count, zero pad
	input  logic                  m_tlast,   // last
	input  logic                  m_tuser,   // crossed
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic             crossed;
		logic [IDX_W-1:0] hit_segment;
		logic             accepted;
		logic             store_full;
		logic [IDX_W-1:0] vertex_index;
		logic [5:0]       crossing_count;
		logic             last;
	} report_t;

	logic [COORD_BITS-1:0]   poly_x [MAX_VERTICES];
	logic [COORD_BITS-1:0]   poly_y [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] seg_marks;
	int                      stored;
	report_t                 expected_reports [$];

	// sign of cross(b - a, c - a) over stored vertices
	function automatic int turn_sign(int a, int b, int c);
		longint ax, ay, ux, uy, vx, vy, cr;
		ax = poly_x[a];
		ay = poly_y[a];
		ux = longint'(poly_x[b]) - ax;
		uy = longint'(poly_y[b]) - ay;
		vx = longint'(poly_x[c]) - ax;
		vy = longint'(poly_y[c]) - ay;
		cr = ux * vy - uy * vx;
		return (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
	endfunction

	task automatic predict_click(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
		int      k, hits, d1, d2, d3, d4;
		report_t r;
		if (stored >= MAX_VERTICES) begin
			r = '0;
			r.store_full = 1'b1;
			r.last = 1'b1;
			expected_reports.push_back(r);
			return;
		end
		k = stored;
		poly_x[k] = x;
		poly_y[k] = y;
		hits = 0;
		for (int i = 0; i + 2 < k; i++) begin
			d1 = turn_sign(i, i + 1, k - 1);
			d2 = turn_sign(i, i + 1, k);
			if (d1 * d2 < 0) begin
				d3 = turn_sign(k - 1, k, i);
				d4 = turn_sign(k - 1, k, i + 1);
				// segment i must touch or straddle the new segment's line
				if (d3 * d4 <= 0) begin
					seg_marks[i] = 1'b1;
					seg_marks[k - 1] = 1'b1;
					r = '0;
					r.crossed = 1'b1;
					r.hit_segment = IDX_W'(i);
					r.accepted = 1'b1;
					r.vertex_index = IDX_W'(k);
					expected_reports.push_back(r);
					hits++;
				end
			end
		end
		r = '0;
		r.accepted = 1'b1;
		r.vertex_index = IDX_W'(k);
		r.crossing_count = 6'(hits);
		r.last = 1'b1;
		expected_reports.push_back(r);
		stored = k + 1;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		report_t want;
		if (!arst_n) begin
			stored = 0;
			seg_marks = '0;
			expected_reports.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// a report at this edge always stems from an earlier click
			if (m_tvalid && m_tready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: report with none expected, expected nothing, got tdata=%h tlast=%b tuser=%b",
						$time, m_tdata, m_tlast, m_tuser);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("crossed", want.crossed, m_tuser);
					check_field("hit_segment", want.hit_segment, m_tdata[5:0]);
					check_field("accepted", want.accepted, m_tdata[6]);
					check_field("store_full", want.store_full, m_tdata[7]);
					check_field("vertex_index", want.vertex_index, m_tdata[13:8]);
					check_field("crossing_count", want.crossing_count, m_tdata[19:14]);
					check_field("pad", 0, m_tdata[23:20]);
					check_field("last", want.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready && s_tuser)
				predict_click(s_tdata[11:0], s_tdata[23:12]);
			pending = expected_reports.size();
		end
	end

endmodule

[tb/sv/tb.sv]
// Testbench top: drives clicks and output stalls into the crossing marker and gives the verdict.
module tb;
	import pscm_pkg::*;

	localparam int CLICKS      = 350;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_OFF    = 400;
	localparam int SETTLE      = 120;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;
	int                    fail_count;
	int                    pending;
	int                    burst_left = 0;
	int                    idle_run   = 0;

	polyline_self_crossing_marker i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	crossing_report_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// one transfer on the input stream; data is {py, px}
	task automatic send_event(input logic click, input logic [IN_DATA_W-1:0] data);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= click;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
	endtask

	// bursts of back-to-back transfers separated by random gaps
	task automatic offer(input logic click, input logic [IN_DATA_W-1:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		send_event(click, data);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		burst_left = 0;
	endtask

	// mostly wide uniform random points, with small grids, repeats and corners for collinear cases
	function automatic logic [IN_DATA_W-1:0] pick_vertex(input logic [IN_DATA_W-1:0] prev);
		logic [COORD_BITS-1:0] x, y;
		case ($urandom_range(0, 9))
			6, 7: begin
				x = COORD_BITS'($urandom_range(0, 7));
				y = COORD_BITS'($urandom_range(0, 7));
			end
			8: return prev;
			9: begin
				x = $urandom_range(0, 1) ? '1 : '0;
				y = $urandom_range(0, 1) ? '1 : '0;
			end
			default: begin
				x = COORD_BITS'($urandom);
				y = COORD_BITS'($urandom);
			end
		endcase
		return {y, x};
	endfunction

	task automatic ready_stretch(output int cycles);
		int mode;
		mode = $urandom_range(0, 3);
		cycles = $urandom_range(8, 40);
		for (int c = 0; c < cycles; c++) begin
			@(negedge clk);
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (c % 8 == 7);
			endcase
		end
	endtask

	initial begin : receiver
		int spent, n;
		spent = 0;
		wait (arst_n);
		while (spent < 200) begin
			ready_stretch(n);
			spent += n;
		end
		// long hold-off: the output backs up and the input stalls
		@(negedge clk);
		m_tready <= 1'b0;
		repeat (HOLD_OFF - 1) @(negedge clk);
		forever ready_stretch(n);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_run <= 0;
		end else if (idle_run == STALL_LIMIT) begin
			$display("FAIL polyline_self_crossing_marker");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	initial begin : stimulus
		logic [COORD_BITS-1:0] x, y;
		logic [IN_DATA_W-1:0]  spot;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		offer(1'b0, '1);
		// opening path: a crossing, degenerate segments, touching, vertical,
		// horizontal and collinear overlaps, reaching the coordinate extremes
		for (int n = 0; n < 15; n++) begin
			case (n)
				0:  begin x = 0;    y = 0;    end
				1:  begin x = 4095; y = 4095; end
				2:  begin x = 0;    y = 4095; end
				3:  begin x = 4095; y = 0;    end
				4:  begin x = 4095; y = 0;    end
				5:  begin x = 2048; y = 2048; end
				6:  begin x = 2048; y = 0;    end
				7:  begin x = 2048; y = 4095; end
				8:  begin x = 0;    y = 2048; end
				9:  begin x = 4095; y = 2048; end
				10: begin x = 4095; y = 2048; end
				11: begin x = 1;    y = 1;    end
				12: begin x = 4094; y = 4094; end
				13: begin x = 4095; y = 1;    end
				default: begin x = 0; y = 4094; end
			endcase
			offer(1'b1, {y, x});
			if (n == 5)
				offer(1'b0, '0);
		end
		wait_drained();

		spot = {y, x};
		for (int n = 15; n < MAX_VERTICES; n++) begin
			if ($urandom_range(0, 5) == 0)
				offer(1'b0, IN_DATA_W'($urandom));
			spot = pick_vertex(spot);
			offer(1'b1, spot);
		end
		wait_drained();

		// store is full from here on: every click is refused
		for (int n = MAX_VERTICES; n < CLICKS; n++) begin
			if ($urandom_range(0, 5) == 0)
				offer(1'b0, IN_DATA_W'($urandom));
			offer(1'b1, IN_DATA_W'($urandom));
		end
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		if (fail_count == 0)
			$display("PASS polyline_self_crossing_marker");
		else
			$display("FAIL polyline_self_crossing_marker");
		$finish;
	end

endmodule
